// ----- rtl/clru_pkg.sv -----
// Package for the cross-layer resonance update block.
// Holds sizes, fixed-point constants, codes, command/status structs and the coupling table.
// No dependencies; every other file uses it by scoped names.
package clru_pkg;

  // Sizes of the layer walk and of the fixed-point format.
  localparam int NUM_LAYERS = 8;
  localparam int FRAC_BITS  = 15;
  localparam int ROM_DEPTH  = 8;
  localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);
  localparam int LIDX_W     = $clog2(NUM_LAYERS);

  // Field widths of the channels and the configuration port.
  localparam int LAYER_W   = 6;
  localparam int ENT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Datapath widths: a value of plus or minus one, one guard bit, and the product.
  localparam int VAL_W  = FRAC_BITS + 2;
  localparam int ACC_W  = VAL_W + 1;
  localparam int PROD_W = ACC_W + VAL_W;

  // One in unsigned and signed forms.
  localparam logic [ENT_W-1:0]        ONE_U   = ENT_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1 << FRAC_BITS);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED   = 1'b0,
    CFG_DAMPING = 1'b1
  } clru_cfg_idx_t;

  // Controller states: accept, three multiplies per layer, then write back.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_COUP,
    ST_MUL_SPEED,
    ST_MUL_KEEP,
    ST_WRITE
  } clru_state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    OP_COUP,
    OP_SPEED,
    OP_KEEP
  } clru_mul_op_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic                    load_item;
    logic                    mul_en;
    clru_mul_op_t            mul_op;
    logic                    write_result;
    logic                    last;
    logic [LIDX_W-1:0]       layer;
  } clru_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic src_ok;
    logic out_free;
  } clru_status_t;

  // exp(-d*d/2) with 24 fractional bits, d = 0 .. ROM_DEPTH-1.
  localparam logic [31:0] COUPLING_Q24 [ROM_DEPTH] = '{
    32'd16777216, 32'd10175896, 32'd2270549, 32'd186378,
    32'd5628,     32'd63,       32'd0,       32'd0
  };

  // Coupling for a layer distance, rounded to FRAC_BITS; zero beyond the table.
  function automatic logic [ENT_W-1:0] coupling_at(input logic [LAYER_W-1:0] d);
    localparam int SH = 24 - FRAC_BITS;
    logic [31:0] q;
    logic [31:0] r;
    if ({1'b0, d} < (LAYER_W+1)'(ROM_DEPTH)) begin
      q = COUPLING_Q24[d[ROM_IDX_W-1:0]];
    end else begin
      q = '0;
    end
    if (SH > 0) begin
      r = (q + (32'd1 << (SH - 1))) >> SH;
    end else begin
      r = q;
    end
    return ENT_W'(r);
  endfunction

endpackage

// ----- rtl/clru_stream_if.sv -----
// Valid/ready channel interfaces for the resonance update block.
// Depends on clru_pkg for the field widths.
interface clru_in_if;
  logic                          valid;
  logic                          ready;
  logic [clru_pkg::LAYER_W-1:0]  src_layer;
  logic [clru_pkg::ENT_W-1:0]    entropy;

  modport source(output valid, src_layer, entropy, input ready);
  modport sink(input valid, src_layer, entropy, output ready);
endinterface

interface clru_out_if;
  logic                               valid;
  logic                               ready;
  logic [clru_pkg::LAYER_W-1:0]       layer_index;
  logic signed [clru_pkg::VAL_W-1:0]  resonance;
  logic                               last;

  modport source(output valid, layer_index, resonance, last, input ready);
  modport sink(input valid, layer_index, resonance, last, output ready);
endinterface

// ----- rtl/cross_layer_resonance_update_top.sv -----
// Top level of the cross-layer resonance update block.
// Depends on clru_pkg, clru_stream_if, clru_ctrl and clru_datapath.
//
//   Channel  Direction  Beat contents
//   upd_in   sink       src_layer, entropy
//   upd_out  source     layer_index, resonance, last
//   cfg      write      cfg_we, cfg_index, cfg_data
//
// An item in range walks all NUM_LAYERS layers: each layer uses the one shared multiplier
// three times, then a write-back. An item whose source layer is out of range is taken in
// the idle state and yields no beat. Reset is synchronous; it clears the resonance store,
// the output valid flag and the controller, and loads the speed and damping defaults.
// A stalled output holds the walk in its write-back step; a new item is taken only
// after the last layer's beat has been registered.
module cross_layer_resonance_update_top (
  input  logic                             clk,
  input  logic                             rst,
  clru_in_if.sink                          upd_in,
  clru_out_if.source                       upd_out,
  input  logic                             cfg_we,
  input  logic [clru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clru_pkg::CFG_W-1:0]       cfg_data
);

  clru_pkg::clru_cmd_t    cmd;
  clru_pkg::clru_status_t status;

  clru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (upd_in.valid),
    .in_ready (upd_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  clru_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_src_layer    (upd_in.src_layer),
    .in_entropy      (upd_in.entropy),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (upd_out.valid),
    .out_ready       (upd_out.ready),
    .out_layer_index (upd_out.layer_index),
    .out_resonance   (upd_out.resonance),
    .out_last        (upd_out.last)
  );

`ifndef SYNTHESIS
  // A result is never written over a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write_result |-> status.out_free)
    else $error("result written over a pending beat");

  // An accepted item in range makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (upd_in.valid && upd_in.ready && status.src_ok) |=> !upd_in.ready)
    else $error("input still ready after starting an update");

  // The last beat reports the final layer.
  a_last_layer: assert property (@(posedge clk) disable iff (rst)
    (upd_out.valid && upd_out.last) |->
      (upd_out.layer_index == clru_pkg::LAYER_W'(clru_pkg::NUM_LAYERS - 1)))
    else $error("last flag on a layer other than the final one");

  // The written value lies within plus or minus one.
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd.write_result |=>
      (upd_out.resonance <= clru_pkg::VAL_W'(1 << clru_pkg::FRAC_BITS) &&
       upd_out.resonance >= -$signed(clru_pkg::VAL_W'(1 << clru_pkg::FRAC_BITS))))
    else $error("resonance outside plus or minus one");
`endif

endmodule

// ----- rtl/clru_ctrl.sv -----
// Controller for the resonance update: walks the layers and sequences the shared multiplier.
// Depends on clru_pkg for the state type and the command/status structs.
module clru_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  clru_pkg::clru_status_t status,
  output clru_pkg::clru_cmd_t    cmd
);

  clru_pkg::clru_state_t            state;
  clru_pkg::clru_state_t            state_next;
  logic [clru_pkg::LIDX_W-1:0]      layer;
  logic [clru_pkg::LIDX_W-1:0]      layer_next;
  logic                             at_last;

  assign at_last = (layer == clru_pkg::LIDX_W'(clru_pkg::NUM_LAYERS - 1));

  // State and layer counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clru_pkg::ST_IDLE;
      layer <= '0;
    end else begin
      state <= state_next;
      layer <= layer_next;
    end
  end

  // Next state and next layer.
  always_comb begin
    state_next = state;
    layer_next = layer;
    unique case (state)
      clru_pkg::ST_IDLE: begin
        layer_next = '0;
        if (in_valid && status.src_ok) begin
          state_next = clru_pkg::ST_MUL_COUP;
        end
      end
      clru_pkg::ST_MUL_COUP:  state_next = clru_pkg::ST_MUL_SPEED;
      clru_pkg::ST_MUL_SPEED: state_next = clru_pkg::ST_MUL_KEEP;
      clru_pkg::ST_MUL_KEEP:  state_next = clru_pkg::ST_WRITE;
      clru_pkg::ST_WRITE: begin
        if (status.out_free) begin
          if (at_last) begin
            state_next = clru_pkg::ST_IDLE;
            layer_next = '0;
          end else begin
            state_next = clru_pkg::ST_MUL_COUP;
            layer_next = layer + 1'b1;
          end
        end
      end
      default: state_next = clru_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready         = 1'b0;
    cmd.load_item    = 1'b0;
    cmd.mul_en       = 1'b0;
    cmd.mul_op       = clru_pkg::OP_COUP;
    cmd.write_result = 1'b0;
    cmd.last         = at_last;
    cmd.layer        = layer;
    unique case (state)
      clru_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      clru_pkg::ST_MUL_COUP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = clru_pkg::OP_COUP;
      end
      clru_pkg::ST_MUL_SPEED: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = clru_pkg::OP_SPEED;
      end
      clru_pkg::ST_MUL_KEEP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = clru_pkg::OP_KEEP;
      end
      clru_pkg::ST_WRITE: begin
        cmd.write_result = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/clru_datapath.sv -----
// Datapath for the resonance update: config registers, resonance store, shared multiplier,
// clamp and the output register. Depends on clru_pkg.
module clru_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [clru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clru_pkg::CFG_W-1:0]          cfg_data,
  input  logic [clru_pkg::LAYER_W-1:0]        in_src_layer,
  input  logic [clru_pkg::ENT_W-1:0]          in_entropy,
  input  clru_pkg::clru_cmd_t                 cmd,
  output clru_pkg::clru_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clru_pkg::LAYER_W-1:0]        out_layer_index,
  output logic signed [clru_pkg::VAL_W-1:0]   out_resonance,
  output logic                                out_last
);

  localparam int AW = clru_pkg::ACC_W;
  localparam int VW = clru_pkg::VAL_W;
  localparam int EW = clru_pkg::ENT_W;

  logic [clru_pkg::CFG_W-1:0]          speed_reg;
  logic [clru_pkg::CFG_W-1:0]          damping_reg;
  logic [clru_pkg::LAYER_W-1:0]        src_reg;
  logic signed [VW-1:0]                signal_reg;
  logic signed [VW-1:0]                store [clru_pkg::NUM_LAYERS];
  logic signed [clru_pkg::PROD_W-1:0]  prod;

  logic [EW-1:0]                       ent_sat;
  logic signed [AW-1:0]                signal_wide;
  logic [EW-1:0]                       speed_eff;
  logic [EW-1:0]                       damp_sat;
  logic [EW-1:0]                       keep;
  logic [clru_pkg::LAYER_W-1:0]        layer_ext;
  logic [clru_pkg::LAYER_W-1:0]        layer_dist;
  logic [EW-1:0]                       coup;
  logic signed [clru_pkg::PROD_W-1:0]  prod_sh;
  logic signed [AW-1:0]                prod_lo;
  logic signed [AW-1:0]                sum;
  logic signed [AW-1:0]                mul_a;
  logic signed [VW-1:0]                mul_b;
  logic signed [AW-1:0]                clamped;

  // Saturate the gains and the entropy to one; the signal is 2*entropy - 1.
  assign ent_sat     = (in_entropy > clru_pkg::ONE_U) ? clru_pkg::ONE_U : in_entropy;
  assign signal_wide = $signed({1'b0, ent_sat, 1'b0}) - clru_pkg::ONE_ACC;
  assign speed_eff   = (speed_reg > clru_pkg::ONE_U) ? clru_pkg::ONE_U : speed_reg;
  assign damp_sat    = (damping_reg > clru_pkg::ONE_U) ? clru_pkg::ONE_U : damping_reg;
  assign keep        = clru_pkg::ONE_U - damp_sat;

  // Layer distance and its coupling.
  assign layer_ext  = clru_pkg::LAYER_W'(cmd.layer);
  assign layer_dist = (src_reg >= layer_ext) ? (src_reg - layer_ext) : (layer_ext - src_reg);
  assign coup       = clru_pkg::coupling_at(layer_dist);

  // Floor shift of the last product and the sum with the stored resonance.
  assign prod_sh = prod >>> clru_pkg::FRAC_BITS;
  assign prod_lo = prod_sh[AW-1:0];
  assign sum     = {store[cmd.layer][VW-1], store[cmd.layer]} + prod_lo;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_op)
      clru_pkg::OP_COUP: begin
        mul_a = {signal_reg[VW-1], signal_reg};
        mul_b = $signed({1'b0, coup});
      end
      clru_pkg::OP_SPEED: begin
        mul_a = prod_lo;
        mul_b = $signed({1'b0, speed_eff});
      end
      clru_pkg::OP_KEEP: begin
        mul_a = sum;
        mul_b = $signed({1'b0, keep});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Clamp the damped value to plus or minus one.
  always_comb begin
    if (prod_lo > clru_pkg::ONE_ACC) begin
      clamped = clru_pkg::ONE_ACC;
    end else if (prod_lo < -clru_pkg::ONE_ACC) begin
      clamped = -clru_pkg::ONE_ACC;
    end else begin
      clamped = prod_lo;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reg   <= clru_pkg::CFG_W'(9830);
      damping_reg <= clru_pkg::CFG_W'(3277);
    end else if (cfg_we) begin
      if (cfg_index == clru_pkg::CFG_SPEED) begin
        speed_reg <= cfg_data;
      end
      if (cfg_index == clru_pkg::CFG_DAMPING) begin
        damping_reg <= cfg_data;
      end
    end
  end

  // Item registers and the product register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      src_reg    <= in_src_layer;
      signal_reg <= signal_wide[VW-1:0];
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Resonance store, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < clru_pkg::NUM_LAYERS; i++) begin
        store[i] <= '0;
      end
    end else if (cmd.write_result) begin
      store[cmd.layer] <= clamped[VW-1:0];
    end
  end

  // Output register: one beat held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_result) begin
      out_layer_index <= layer_ext;
      out_resonance   <= clamped[VW-1:0];
      out_last        <= cmd.last;
    end
  end

  // Status to the controller.
  assign status.src_ok   = ({1'b0, in_src_layer} <
                            (clru_pkg::LAYER_W+1)'(clru_pkg::NUM_LAYERS));
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- test/cross_layer_resonance_update_top_tb.sv -----
// Self-checking testbench for cross_layer_resonance_update_top: a layer-walk predictor,
// a queue-fed valid/ready driver, a beat checker and random stalls on both channels.
// Depends on clru_pkg, clru_stream_if and the RTL of the block.
module cross_layer_resonance_update_top_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam logic [clru_pkg::ENT_W-1:0] FX_ONE =
    clru_pkg::ENT_W'(1 << clru_pkg::FRAC_BITS);

  // exp(-d*d/2) in Q1.15 for layer distances 0 to 7.
  localparam longint COUPLING_FX [8] = '{32768, 19875, 4435, 364, 11, 0, 0, 0};

  typedef struct {
    logic [clru_pkg::LAYER_W-1:0] src;
    logic [clru_pkg::ENT_W-1:0]   ent;
  } update_item_t;

  typedef struct {
    logic [clru_pkg::LAYER_W-1:0]      layer;
    logic signed [clru_pkg::VAL_W-1:0] res;
    logic                              last;
  } layer_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [clru_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [clru_pkg::CFG_W-1:0] cfg_data;

  clru_in_if  upd_in_ch();
  clru_out_if upd_out_ch();

  cross_layer_resonance_update_top DUT (
    .clk       (clk),
    .rst       (rst),
    .upd_in    (upd_in_ch),
    .upd_out   (upd_out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: configuration copy and per-layer resonance.
  logic [clru_pkg::CFG_W-1:0] model_speed = 16'd9830;
  logic [clru_pkg::CFG_W-1:0] model_damping = 16'd3277;
  longint resonance_fx [clru_pkg::NUM_LAYERS];

  update_item_t pending_updates [$];
  layer_result_t expected_layers [$];

  bit in_idle_en;
  bit out_idle_en;
  bit hold_out_arm;
  bit hold_out_done;
  int in_gap;
  int out_hold;
  int errors;
  int updates_taken;
  int ignored_taken;
  int beats_checked;
  int cycle_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Walk all layers for one accepted update and queue the resonance beats it yields.
  function automatic void predict_update(logic [clru_pkg::LAYER_W-1:0] src,
                                         logic [clru_pkg::ENT_W-1:0] ent);
    longint ent_fx;
    longint spd;
    longint keep;
    longint sig;
    longint coup;
    longint ripple;
    longint v;
    int layer_dist;
    int l;
    layer_result_t r;
    if (int'(src) >= clru_pkg::NUM_LAYERS) begin
      ignored_taken++;
      return;
    end
    updates_taken++;
    ent_fx = (ent > FX_ONE) ? longint'(FX_ONE) : longint'(ent);
    spd = (model_speed > FX_ONE) ? longint'(FX_ONE) : longint'(model_speed);
    keep = longint'(FX_ONE) - ((model_damping > FX_ONE) ? longint'(FX_ONE)
                                                         : longint'(model_damping));
    sig = 2 * ent_fx - longint'(FX_ONE);
    for (l = 0; l < clru_pkg::NUM_LAYERS; l++) begin
      layer_dist = int'(src) - l;
      if (layer_dist < 0) begin
        layer_dist = -layer_dist;
      end
      coup = (layer_dist < 8) ? COUPLING_FX[layer_dist] : 0;
      // Truncating products: arithmetic shift rounds toward minus infinity.
      ripple = (((sig * coup) >>> clru_pkg::FRAC_BITS) * spd) >>> clru_pkg::FRAC_BITS;
      v = ((resonance_fx[l] + ripple) * keep) >>> clru_pkg::FRAC_BITS;
      if (v > longint'(FX_ONE)) begin
        v = longint'(FX_ONE);
      end
      if (v < -longint'(FX_ONE)) begin
        v = -longint'(FX_ONE);
      end
      resonance_fx[l] = v;
      r.layer = clru_pkg::LAYER_W'(l);
      r.res = clru_pkg::VAL_W'(v);
      r.last = (l == clru_pkg::NUM_LAYERS - 1);
      expected_layers.push_back(r);
    end
  endfunction

  // Input driver: predicts on each accepted beat and feeds the channel from the queue.
  always @(posedge clk) begin
    logic next_valid;
    update_item_t item;
    if (rst) begin
      upd_in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (upd_in_ch.valid && upd_in_ch.ready) begin
        predict_update(upd_in_ch.src_layer, upd_in_ch.entropy);
      end
      if (!upd_in_ch.valid || upd_in_ch.ready) begin
        next_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_updates.size() > 0) begin
          if (in_idle_en && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 18) - 1;
          end else begin
            item = pending_updates.pop_front();
            next_valid = 1'b1;
            upd_in_ch.src_layer <= item.src;
            upd_in_ch.entropy <= item.ent;
          end
        end
        upd_in_ch.valid <= next_valid;
      end
    end
  end

  // Output ready: random stall bursts plus one long hold that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      upd_out_ch.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (hold_out_arm && !hold_out_done) begin
        hold_out_done = 1'b1;
        out_hold = LONG_HOLD;
      end
      if (out_hold > 0) begin
        out_hold--;
        upd_out_ch.ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(1, 18) - 1;
        upd_out_ch.ready <= 1'b0;
      end else begin
        upd_out_ch.ready <= 1'b1;
      end
    end
  end

  // Beat checker: each output beat against the oldest expected layer result.
  always @(posedge clk) begin
    layer_result_t e;
    if (!rst && upd_out_ch.valid && upd_out_ch.ready) begin
      if (expected_layers.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: layer %0d resonance %0d last %0b", $time,
                 upd_out_ch.layer_index, upd_out_ch.resonance, upd_out_ch.last);
      end else begin
        e = expected_layers.pop_front();
        beats_checked++;
        if (upd_out_ch.layer_index !== e.layer || upd_out_ch.resonance !== e.res ||
            upd_out_ch.last !== e.last) begin
          errors++;
          $display("%0t: beat mismatch: expected layer %0d resonance %0d last %0b, got %0d %0d %0b",
                   $time, e.layer, e.res, e.last, upd_out_ch.layer_index,
                   upd_out_ch.resonance, upd_out_ch.last);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d layer results outstanding", $time, expected_layers.size());
      $display("cross_layer_resonance_update_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(clru_pkg::clru_cfg_idx_t idx, logic [clru_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == clru_pkg::CFG_SPEED) begin
      model_speed = value;
    end else begin
      model_damping = value;
    end
  endtask

  task automatic queue_update(int src, int ent);
    update_item_t item;
    item.src = clru_pkg::LAYER_W'(src);
    item.ent = clru_pkg::ENT_W'(ent);
    pending_updates.push_back(item);
  endtask

  // Mostly in-range layers with varied entropy; some ignored layers and raw 16-bit values.
  task automatic queue_random(int count);
    int k;
    int src;
    int ent;
    for (k = 0; k < count; k++) begin
      src = ($urandom_range(0, 9) == 0) ? $urandom_range(clru_pkg::NUM_LAYERS, 63)
                                        : $urandom_range(0, clru_pkg::NUM_LAYERS - 1);
      case ($urandom_range(0, 4))
        0: ent = $urandom_range(0, 65535);
        1: ent = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300)
                                             : $urandom_range(32468, 32768);
        default: ent = $urandom_range(0, 32768);
      endcase
      queue_update(src, ent);
    end
  endtask

  // Wait until the block is idle with nothing outstanding, then let it settle.
  // The check runs on the falling edge so that every beat of the rising edge has landed.
  task automatic drain();
    while (pending_updates.size() > 0 || upd_in_ch.valid || expected_layers.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < clru_pkg::NUM_LAYERS; i++) begin
      resonance_fx[i] = 0;
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = clru_pkg::CFG_SPEED;
    cfg_data = '0;
    upd_in_ch.valid = 1'b0;
    upd_in_ch.src_layer = '0;
    upd_in_ch.entropy = '0;
    upd_out_ch.ready = 1'b0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: entropy extremes, ignored layers, entropy above one.
    queue_update(0, 0);
    queue_update(clru_pkg::NUM_LAYERS - 1, 32768);
    queue_update(3, 16384);
    queue_update(clru_pkg::NUM_LAYERS, 20000);
    queue_update(63, 65535);
    queue_update(0, 65535);
    queue_update(clru_pkg::NUM_LAYERS - 1, 0);
    queue_update(4, 32767);
    queue_update(5, 1);
    queue_update(2, 49152);
    queue_random(25);
    drain();

    // Full gain with no damping drives layers into both clamps; long output hold.
    write_reg(clru_pkg::CFG_SPEED, 16'd32768);
    write_reg(clru_pkg::CFG_DAMPING, 16'd0);
    queue_update(3, 32768);
    queue_update(3, 32768);
    queue_update(4, 32768);
    queue_update(3, 0);
    queue_update(3, 0);
    queue_update(4, 0);
    queue_update(4, 0);
    queue_random(25);
    hold_out_arm = 1'b1;
    drain();

    // Gain and damping above one: saturated, and full damping zeroes every layer.
    write_reg(clru_pkg::CFG_SPEED, 16'd65535);
    write_reg(clru_pkg::CFG_DAMPING, 16'd65535);
    queue_update(0, 32768);
    queue_update(clru_pkg::NUM_LAYERS - 1, 0);
    queue_random(15);
    drain();

    // No gain, half damping: resonance only decays.
    write_reg(clru_pkg::CFG_SPEED, 16'd0);
    write_reg(clru_pkg::CFG_DAMPING, 16'd32768);
    queue_random(10);
    drain();

    // Random speed over the full width and damping up to 40000, with no idling on either side.
    write_reg(clru_pkg::CFG_SPEED, 16'($urandom_range(0, 65535)));
    write_reg(clru_pkg::CFG_DAMPING, 16'($urandom_range(0, 40000)));
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    queue_random(30);
    drain();

    $display("Run covered %0d layer updates and %0d ignored source layers, %0d beats checked,",
             updates_taken, ignored_taken, beats_checked);
    $display("over five register settings including zero, one and saturated values.");
    if (errors == 0) begin
      $display("cross_layer_resonance_update_top verification clean");
    end else begin
      $display("cross_layer_resonance_update_top verification failed");
    end
    $finish;
  end

endmodule
